// ===== design/frc_pkg.sv =====
package frc_pkg;

  localparam int PAYLOAD_LIMIT = 4096;

  localparam logic [7:0]  START_BYTE = 8'h7E;
  localparam logic [15:0] CHECK_POLY = 16'h1021;

  // event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PAYLOAD  = 2'd1;
  localparam logic [1:0] EV_ACCEPTED = 2'd2;
  localparam logic [1:0] EV_REJECTED = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_WRONG_CMD = 3'd3;
  localparam logic [2:0] ERR_BAD_CHECK = 3'd4;

  // configuration register indexes
  localparam logic REG_EXPECTED_COMMAND = 1'b0;
  localparam logic REG_MAX_PAYLOAD      = 1'b1;

  typedef struct packed {
    logic [7:0]  expected_command;
    logic [12:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } item_t;

  // one byte of the running check: xor into upper half, one conditional shift
  function automatic logic [15:0] check_update(input logic [15:0] chk, input logic [7:0] b);
    logic [15:0] t;
    t = chk ^ {b, 8'h00};
    if (t[15]) begin
      check_update = {t[14:0], 1'b0} ^ CHECK_POLY;
    end else begin
      check_update = {t[14:0], 1'b0};
    end
  endfunction

endpackage

// ===== design/frc_byte_if.sv =====
interface frc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/frc_res_if.sv =====
interface frc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic [11:0] payload_index;
  logic [12:0] frame_length;
  logic [2:0]  error_kind;

  modport source (output valid, output event_res, output payload_byte, output payload_index,
                  output frame_length, output error_kind, input ready);
  modport sink (input valid, input event_res, input payload_byte, input payload_index,
                input frame_length, input error_kind, output ready);
endinterface

// ===== design/frc_in_stage.sv =====
module frc_in_stage
  import frc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  frc_byte_if.sink   rx,
  input  logic       take,
  output item_t      item
);

  logic       held;
  logic [7:0] data;

  assign rx.ready   = !held || take;
  assign item.valid = held;
  assign item.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

// ===== design/frc_parser.sv =====
module frc_parser
  import frc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  cfg_t       cfg,
  output logic       take,
  frc_res_if.source  res
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_TRAILER = 2'd3;

  localparam logic [31:0] LIMIT_CAP = 32'(PAYLOAD_LIMIT);

  logic [1:0]  phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] declared_length, declared_length_next;
  logic [12:0] payload_count, payload_count_next;
  logic [15:0] running_check, running_check_next;
  logic [15:0] received_check, received_check_next;
  logic [1:0]  trailer_count, trailer_count_next;
  logic        type_bad, type_bad_next;
  logic        trailer_bad, trailer_bad_next;

  logic        out_valid;
  logic [1:0]  ev, ev_next;
  logic [7:0]  pbyte, pbyte_next;
  logic [11:0] pidx, pidx_next;
  logic [12:0] flen, flen_next;
  logic [2:0]  err, err_next;

  logic [7:0]  b;
  logic [31:0] limit;
  logic [15:0] chk_upd;
  logic [12:0] count_inc;
  logic        hunt_restart;

  assign b         = item.data;
  assign take      = item.valid && (!out_valid || res.ready);
  assign chk_upd   = check_update(running_check, b);
  assign count_inc = payload_count + 13'd1;
  assign limit     = ({19'd0, cfg.max_payload} > LIMIT_CAP) ? LIMIT_CAP
                                                           : {19'd0, cfg.max_payload};

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    running_check_next   = running_check;
    received_check_next  = received_check;
    trailer_count_next   = trailer_count;
    type_bad_next        = type_bad;
    trailer_bad_next     = trailer_bad;
    ev_next              = EV_NONE;
    pbyte_next           = 8'd0;
    pidx_next            = 12'd0;
    flen_next            = 13'd0;
    err_next             = ERR_NONE;
    hunt_restart         = 1'b0;

    case (phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          hunt_restart = 1'b1;
        end
      end
      PH_HEADER: begin
        running_check_next = chk_upd;
        case (header_count)
          3'd0: type_bad_next = (b != 8'd0);
          3'd1: declared_length_next[7:0]   = b;
          3'd2: declared_length_next[15:8]  = b;
          3'd3: declared_length_next[23:16] = b;
          3'd4: declared_length_next[31:24] = b;
          default: ;
        endcase
        if (header_count < 3'd5) begin
          header_count_next = header_count + 3'd1;
        end else begin
          // command byte: judge whole header, first fault wins
          if (type_bad) begin
            err_next = ERR_BAD_TYPE;
          end else if (declared_length > limit) begin
            err_next = ERR_TOO_LONG;
          end else if (b != cfg.expected_command) begin
            err_next = ERR_WRONG_CMD;
          end
          if (err_next != ERR_NONE) begin
            ev_next      = EV_REJECTED;
            hunt_restart = 1'b1;
          end else begin
            header_count_next  = 3'd0;
            payload_count_next = 13'd0;
            phase_next = (declared_length == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        running_check_next = chk_upd;
        ev_next            = EV_PAYLOAD;
        pbyte_next         = b;
        pidx_next          = payload_count[11:0];
        payload_count_next = count_inc;
        // length was checked against the cap, so upper bits are zero here
        if (count_inc >= declared_length[12:0]) begin
          phase_next = PH_TRAILER;
        end
      end
      default: begin
        trailer_count_next = trailer_count + 2'd1;
        case (trailer_count)
          2'd0: received_check_next = {b, 8'd0};
          2'd1: received_check_next = {received_check[15:8], b};
          2'd2: trailer_bad_next = trailer_bad || (b != 8'd0);
          default: begin
            if (trailer_bad || (b != 8'd0) || (received_check != running_check)) begin
              ev_next  = EV_REJECTED;
              err_next = ERR_BAD_CHECK;
            end else begin
              ev_next   = EV_ACCEPTED;
              flen_next = declared_length[12:0];
            end
            hunt_restart = 1'b1;
          end
        endcase
      end
    endcase

    if (hunt_restart) begin
      // a start byte in hunt opens a header, anything else ends the frame
      phase_next           = (phase == PH_HUNT) ? PH_HEADER : PH_HUNT;
      header_count_next    = 3'd0;
      declared_length_next = 32'd0;
      payload_count_next   = 13'd0;
      running_check_next   = 16'd0;
      received_check_next  = 16'd0;
      trailer_count_next   = 2'd0;
      type_bad_next        = 1'b0;
      trailer_bad_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      header_count    <= 3'd0;
      declared_length <= 32'd0;
      payload_count   <= 13'd0;
      running_check   <= 16'd0;
      received_check  <= 16'd0;
      trailer_count   <= 2'd0;
      type_bad        <= 1'b0;
      trailer_bad     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        declared_length <= declared_length_next;
        payload_count   <= payload_count_next;
        running_check   <= running_check_next;
        received_check  <= received_check_next;
        trailer_count   <= trailer_count_next;
        type_bad        <= type_bad_next;
        trailer_bad     <= trailer_bad_next;
        out_valid       <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev    <= ev_next;
      pbyte <= pbyte_next;
      pidx  <= pidx_next;
      flen  <= flen_next;
      err   <= err_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.event_res     = ev;
  assign res.payload_byte  = pbyte;
  assign res.payload_index = pidx;
  assign res.frame_length  = flen;
  assign res.error_kind    = err;

`ifndef SYNTH
  // hunting state carries nothing from an earlier frame
  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> (running_check == 16'd0 && header_count == 3'd0))
    else $error("stale frame state while hunting");

  // payload phase only with a nonzero length within the cap
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> (declared_length != 32'd0 && declared_length <= LIMIT_CAP))
    else $error("payload phase with bad length");

  // error code present exactly when a rejection is reported
  a_err_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ev == EV_REJECTED) == (err != ERR_NONE)))
    else $error("error code does not match event");

  // a payload result leaves the frame still open
  a_payload_open: assert property (@(posedge clk) disable iff (rst)
    take && ev_next == EV_PAYLOAD |=> phase == PH_PAYLOAD || phase == PH_TRAILER)
    else $error("frame closed on payload byte");
`endif

endmodule

// ===== design/frame_receiver_with_check.sv =====
// Frame receiver: takes one received byte per item and returns exactly one result item
// per byte. It hunts for the start byte 0x7E, reads a six-byte header (type, 32-bit
// little-endian length, command), forwards payload bytes with their index, then checks the
// big-endian 16-bit running check and two zero trailer bytes, reporting accept or reject.
// Throughput is one byte per cycle while the sink takes results. The accepted byte waits in
// the input register; the single-pass parser loads its result into the result register when
// it takes the byte. A result held by the sink stalls the input once both registers
// are full. Configuration (expected_command at index 0, max_payload at index 1) is written
// through cfg_we, and the user must do so only while the block is idle; the block does not
// enforce this. The effective length limit is the smaller of max_payload and 4096.
module frame_receiver_with_check
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  frc_byte_if.sink    rx,
  frc_res_if.source   res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_command <= 8'd160;
      cfg.max_payload      <= 13'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_COMMAND: cfg.expected_command <= cfg_data[7:0];
        REG_MAX_PAYLOAD:      cfg.max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  frc_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .item (item)
  );

  frc_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cfg  (cfg),
    .take (take),
    .res  (res)
  );

endmodule
